// ----- sv/cdt_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the cube direction to texel block.
// No dependencies; every other file imports this package.
package cdt_pkg;

    // Fixed field widths of the ports
    localparam int TEXEL_BITS     = 12;
    localparam int CFG_DATA_BITS  = 13;
    localparam int CFG_INDEX_BITS = 2;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_BITS-1:0] REG_FACE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FACE_HEIGHT = 2'd1;

    localparam logic [CFG_DATA_BITS-1:0] FACE_SIZE_RESET = 13'd256;

    // Face codes: positive and negative face of each axis
    typedef enum logic [2:0] {
        FACE_POS_X = 3'd0,
        FACE_NEG_X = 3'd1,
        FACE_POS_Y = 3'd2,
        FACE_NEG_Y = 3'd3,
        FACE_POS_Z = 3'd4,
        FACE_NEG_Z = 3'd5
    } t_face;

    // Side information that rides along with the arithmetic
    typedef struct packed {
        t_face face;
        logic  zero;
    } t_tag;

endpackage

// ----- sv/cdt_select.sv -----
`timescale 1ns / 1ps
// Major axis selection: absolute values, face choice and face coordinates.
// Depends on cdt_pkg; one register stage.
module cdt_select
    import cdt_pkg::*;
#(
    parameter int CB = 16
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [CB-1:0] i_dir_x,
    input  logic signed [CB-1:0] i_dir_y,
    input  logic signed [CB-1:0] i_dir_z,
    output t_tag                 o_tag,
    output logic [CB-1:0]        o_m,
    output logic [CB:0]          o_s,
    output logic [CB:0]          o_t
);

    logic [CB-1:0] w_ax, w_ay, w_az;
    logic [CB:0]   w_xe, w_ye, w_ze;
    t_tag          n_tag;
    logic [CB-1:0] n_m;
    logic [CB:0]   n_s, n_t;
    t_tag          r_tag;
    logic [CB-1:0] r_m;
    logic [CB:0]   r_s, r_t;

    // Magnitudes; the most negative value maps to its unsigned magnitude
    assign w_ax = i_dir_x[CB-1] ? (~i_dir_x + 1'b1) : i_dir_x;
    assign w_ay = i_dir_y[CB-1] ? (~i_dir_y + 1'b1) : i_dir_y;
    assign w_az = i_dir_z[CB-1] ? (~i_dir_z + 1'b1) : i_dir_z;

    // Sign-extend by one bit so negation never overflows
    assign w_xe = {i_dir_x[CB-1], i_dir_x};
    assign w_ye = {i_dir_y[CB-1], i_dir_y};
    assign w_ze = {i_dir_z[CB-1], i_dir_z};

    // Pick major axis; ties go to x, then y
    always_comb begin
        n_tag.zero = (w_ax == '0) && (w_ay == '0) && (w_az == '0);
        if ((w_ax >= w_ay) && (w_ax >= w_az)) begin
            n_m = w_ax;
            n_t = -w_ye;
            if (!i_dir_x[CB-1]) begin
                n_tag.face = FACE_POS_X;
                n_s        = -w_ze;
            end else begin
                n_tag.face = FACE_NEG_X;
                n_s        = w_ze;
            end
        end else if (w_ay >= w_az) begin
            n_m = w_ay;
            n_s = w_xe;
            if (!i_dir_y[CB-1]) begin
                n_tag.face = FACE_POS_Y;
                n_t        = w_ze;
            end else begin
                n_tag.face = FACE_NEG_Y;
                n_t        = -w_ze;
            end
        end else begin
            n_m = w_az;
            n_t = -w_ye;
            if (!i_dir_z[CB-1]) begin
                n_tag.face = FACE_POS_Z;
                n_s        = w_xe;
            end else begin
                n_tag.face = FACE_NEG_Z;
                n_s        = -w_xe;
            end
        end
    end

    // Hold on stall, advance otherwise
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag <= n_tag;
            r_m   <= n_m;
            r_s   <= n_s;
            r_t   <= n_t;
        end
    end

    assign o_tag = r_tag;
    assign o_m   = r_m;
    assign o_s   = r_s;
    assign o_t   = r_t;

endmodule

// ----- sv/cdt_scale.sv -----
`timescale 1ns / 1ps
// Numerator and divisor build-up: offset, multiply by face size, add bias.
// Depends on cdt_pkg; three register stages.
module cdt_scale
    import cdt_pkg::*;
#(
    parameter int CB = 16,
    parameter int SB = 13
) (
    input  logic             i_clk,
    input  logic [2:0]       i_en,
    input  logic [CB-1:0]    i_m,
    input  logic [CB:0]      i_s,
    input  logic [CB:0]      i_t,
    input  logic [SB-1:0]    i_eff_w,
    input  logic [SB-1:0]    i_eff_h,
    output logic [CB+SB:0]   o_num_x,
    output logic [CB+SB:0]   o_num_y,
    output logic [CB:0]      o_den
);

    localparam int DW = CB + SB + 1;

    logic [CB:0]   r_u, r_v;
    logic [CB-1:0] r_m1, r_m2;
    logic [DW-1:0] r_pu, r_pv;
    logic [DW-1:0] r_num_x, r_num_y;
    logic [CB:0]   r_den;

    // Offset: u = s + m lies in 0..2m, so modular add is exact
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_u  <= i_s + {1'b0, i_m};
            r_v  <= i_t + {1'b0, i_m};
            r_m1 <= i_m;
        end
    end

    // Multiply by the face size
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_pu <= DW'(r_u) * DW'(i_eff_w);
            r_pv <= DW'(r_v) * DW'(i_eff_h);
            r_m2 <= r_m1;
        end
    end

    // Add half-texel bias m; divisor is 2m
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_num_x <= r_pu + DW'(r_m2);
            r_num_y <= r_pv + DW'(r_m2);
            r_den   <= {r_m2, 1'b0};
        end
    end

    assign o_num_x = r_num_x;
    assign o_num_y = r_num_y;
    assign o_den   = r_den;

endmodule

// ----- sv/cdt_divider.sv -----
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on cdt_pkg; instantiated once per texel axis.
module cdt_divider
    import cdt_pkg::*;
#(
    parameter int CB = 16,
    parameter int SB = 13
) (
    input  logic             i_clk,
    input  logic [SB-1:0]    i_en,
    input  logic [CB+SB:0]   i_num,
    input  logic [CB:0]      i_den,
    output logic [SB-1:0]    o_quo
);

    localparam int DW = CB + SB + 1;

    logic [DW-1:0] r_rem [SB];
    logic [CB:0]   r_den [SB];
    logic [SB-1:0] r_quo [SB];

    for (genvar j = 0; j < SB; j++) begin : gen_stage
        localparam int B = SB - 1 - j;

        logic [DW-1:0] w_rem_in;
        logic [CB:0]   w_den_in;
        logic [SB-1:0] w_quo_in;
        logic [DW-1:0] w_trial;

        if (j == 0) begin : gen_first
            assign w_rem_in = i_num;
            assign w_den_in = i_den;
            assign w_quo_in = '0;
        end else begin : gen_next
            assign w_rem_in = r_rem[j-1];
            assign w_den_in = r_den[j-1];
            assign w_quo_in = r_quo[j-1];
        end

        assign w_trial = DW'(w_den_in) << B;

        // Subtract the shifted divisor when it fits, set the quotient bit
        always_ff @(posedge i_clk) begin
            if (i_en[j]) begin
                r_den[j] <= w_den_in;
                if (w_rem_in >= w_trial) begin
                    r_rem[j] <= w_rem_in - w_trial;
                    r_quo[j] <= w_quo_in | (SB'(1) << B);
                end else begin
                    r_rem[j] <= w_rem_in;
                    r_quo[j] <= w_quo_in;
                end
            end
        end
    end

    assign o_quo = r_quo[SB-1];

endmodule

// ----- sv/cube_direction_to_texel.sv -----
`timescale 1ns / 1ps
// Cube map face selection and texel addressing, top level.
// Depends on cdt_pkg, cdt_select, cdt_scale, cdt_divider.
//
// Usage:
//   Input channel i_valid / o_stall carries a signed direction (x, y, z).
//   Output channel o_valid / i_stall returns face, texel column and row,
//   and a flag for the all-zero direction. One result per item, in order.
//   The configuration channel i_cfg_valid / o_cfg_ready writes face width
//   (index 0) and face height (index 1); o_cfg_ready is always high.
//   Write it only while no item is in flight.
// Pipeline: select, offset, multiply, bias, the divider stages and the
//   output register, from acceptance to o_valid. The quotient is produced one
//   bit per stage by a pipelined divider, which sets the pipeline depth.
// Throughput: one item per cycle unless stalled; no state links items.
// Reset: clears all valid bits and restores both face sizes to 256.
// Stall: a stalled result holds in the output register; upstream stages
//   keep accepting until every stage holds an item, then o_stall rises.
module cube_direction_to_texel
    import cdt_pkg::*;
#(
    parameter int COMPONENT_BITS = 16,
    parameter int MAX_FACE_SIZE  = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic signed [COMPONENT_BITS-1:0] i_dir_x,
    input  logic signed [COMPONENT_BITS-1:0] i_dir_y,
    input  logic signed [COMPONENT_BITS-1:0] i_dir_z,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [2:0]                       o_face,
    output logic [TEXEL_BITS-1:0]            o_texel_x,
    output logic [TEXEL_BITS-1:0]            o_texel_y,
    output logic                             o_zero_direction,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]        i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]         i_cfg_data
);

    localparam int CB = COMPONENT_BITS;
    localparam int SB = $clog2(MAX_FACE_SIZE + 1);
    localparam int DW = CB + SB + 1;
    // select, offset, multiply, bias, SB divider steps, output
    localparam int NS = SB + 5;
    localparam int DIV0 = 4;

    logic [CFG_DATA_BITS-1:0] r_face_w, r_face_h;
    logic [SB-1:0]            n_eff_w, n_eff_h, r_eff_w, r_eff_h;
    logic [NS-1:0]            r_vld;
    logic [NS-1:0]            w_en;

    t_tag                     w_tag0;
    logic [CB-1:0]            w_m;
    logic [CB:0]              w_s, w_t;
    logic [DW-1:0]            w_num_x, w_num_y;
    logic [CB:0]              w_den;
    logic [SB-1:0]            w_qx, w_qy;
    logic [SB-1:0]            n_cx, n_cy;

    t_tag                     r_tag [1:NS-2];
    logic [2:0]               r_face;
    logic [TEXEL_BITS-1:0]    r_tx, r_ty;
    logic                     r_zero;

    // Configuration writes; unknown indexes are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face_w <= FACE_SIZE_RESET;
            r_face_h <= FACE_SIZE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_FACE_WIDTH:  r_face_w <= i_cfg_data;
                REG_FACE_HEIGHT: r_face_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Effective sizes: zero acts as one, clamp to the largest face
    always_comb begin
        if (r_face_w == '0) begin
            n_eff_w = SB'(1);
        end else if (32'(r_face_w) > 32'(MAX_FACE_SIZE)) begin
            n_eff_w = SB'(MAX_FACE_SIZE);
        end else begin
            n_eff_w = SB'(r_face_w);
        end
        if (r_face_h == '0) begin
            n_eff_h = SB'(1);
        end else if (32'(r_face_h) > 32'(MAX_FACE_SIZE)) begin
            n_eff_h = SB'(MAX_FACE_SIZE);
        end else begin
            n_eff_h = SB'(r_face_h);
        end
    end

    always_ff @(posedge i_clk) begin
        r_eff_w <= n_eff_w;
        r_eff_h <= n_eff_h;
    end

    // Stage advance: a stage moves when empty or when its successor moves
    always_comb begin
        w_en[NS-1] = !r_vld[NS-1] || !i_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_stall = !w_en[0];

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    cdt_select #(
        .CB (CB)
    ) u_select (
        .i_clk   (i_clk),
        .i_en    (w_en[0]),
        .i_dir_x (i_dir_x),
        .i_dir_y (i_dir_y),
        .i_dir_z (i_dir_z),
        .o_tag   (w_tag0),
        .o_m     (w_m),
        .o_s     (w_s),
        .o_t     (w_t)
    );

    cdt_scale #(
        .CB (CB),
        .SB (SB)
    ) u_scale (
        .i_clk   (i_clk),
        .i_en    (w_en[3:1]),
        .i_m     (w_m),
        .i_s     (w_s),
        .i_t     (w_t),
        .i_eff_w (r_eff_w),
        .i_eff_h (r_eff_h),
        .o_num_x (w_num_x),
        .o_num_y (w_num_y),
        .o_den   (w_den)
    );

    cdt_divider #(
        .CB (CB),
        .SB (SB)
    ) u_div_x (
        .i_clk (i_clk),
        .i_en  (w_en[DIV0+SB-1:DIV0]),
        .i_num (w_num_x),
        .i_den (w_den),
        .o_quo (w_qx)
    );

    cdt_divider #(
        .CB (CB),
        .SB (SB)
    ) u_div_y (
        .i_clk (i_clk),
        .i_en  (w_en[DIV0+SB-1:DIV0]),
        .i_num (w_num_y),
        .i_den (w_den),
        .o_quo (w_qy)
    );

    // Carry face and zero flag alongside the arithmetic
    for (genvar k = 1; k <= NS - 2; k++) begin : gen_tag
        if (k == 1) begin : gen_first
            always_ff @(posedge i_clk) begin
                if (w_en[k]) begin
                    r_tag[k] <= w_tag0;
                end
            end
        end else begin : gen_next
            always_ff @(posedge i_clk) begin
                if (w_en[k]) begin
                    r_tag[k] <= r_tag[k-1];
                end
            end
        end
    end

    // Clamp the quotient to size minus one
    assign n_cx = (w_qx >= r_eff_w) ? (r_eff_w - SB'(1)) : w_qx;
    assign n_cy = (w_qy >= r_eff_h) ? (r_eff_h - SB'(1)) : w_qy;

    // Output register; a zero direction forces face and texel to zero
    always_ff @(posedge i_clk) begin
        if (w_en[NS-1]) begin
            r_zero <= r_tag[NS-2].zero;
            if (r_tag[NS-2].zero) begin
                r_face <= FACE_POS_X;
                r_tx   <= '0;
                r_ty   <= '0;
            end else begin
                r_face <= r_tag[NS-2].face;
                r_tx   <= TEXEL_BITS'(n_cx);
                r_ty   <= TEXEL_BITS'(n_cy);
            end
        end
    end

    assign o_valid          = r_vld[NS-1];
    assign o_face           = r_face;
    assign o_texel_x        = r_tx;
    assign o_texel_y        = r_ty;
    assign o_zero_direction = r_zero;

endmodule

// ----- sv/cdt_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the cube direction to texel block, with its bind.
// Depends on cdt_pkg and the top level cube_direction_to_texel.
module cdt_checker
    import cdt_pkg::*;
#(
    parameter int COMPONENT_BITS = 16
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_valid,
    input logic                             o_stall,
    input logic signed [COMPONENT_BITS-1:0] i_dir_x,
    input logic signed [COMPONENT_BITS-1:0] i_dir_y,
    input logic signed [COMPONENT_BITS-1:0] i_dir_z,
    input logic                             o_valid,
    input logic                             i_stall,
    input logic [2:0]                       o_face,
    input logic [TEXEL_BITS-1:0]            o_texel_x,
    input logic [TEXEL_BITS-1:0]            o_texel_y,
    input logic                             o_zero_direction,
    input logic                             i_cfg_valid,
    input logic                             o_cfg_ready,
    input logic [CFG_INDEX_BITS-1:0]        i_cfg_index,
    input logic [CFG_DATA_BITS-1:0]         i_cfg_data
);

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_face) && $stable(o_texel_x)
            && $stable(o_texel_y) && $stable(o_zero_direction))
        else $error("stalled result changed");

    // Input back-pressure only when the output holds an item
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled with room in the pipeline");

    // Zero direction reports face zero and texel origin
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_direction |->
            o_face == FACE_POS_X && o_texel_x == '0 && o_texel_y == '0)
        else $error("zero direction with nonzero face or texel");

    // Face stays within the six faces
    a_face: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_face <= FACE_NEG_Z)
        else $error("face code out of range");

endmodule

bind cube_direction_to_texel cdt_checker #(
    .COMPONENT_BITS (COMPONENT_BITS)
) u_cdt_checker (.*);
